// ----- design/gmps_pkg.sv -----
package gmps_pkg;

   localparam int GOLD_W      = 16;
   localparam int SCORE_W     = 24;
   localparam int ROW_COUNT_W = 7;
   localparam int COL_COUNT_W = 9;
   localparam int CSR_DATA_W  = 9;
   localparam int CSR_INDEX_W = 1;

   localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

   localparam int ROW_COUNT_RESET = 8;
   localparam int COL_COUNT_RESET = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COL_COUNT = 1'b1;

   // neighbour selection for one cell
   typedef struct packed {
      logic first_col;
      logic has_above;
      logic has_below;
   } gmps_ctx_type;

endpackage

// ----- design/gmps_score.sv -----
module gmps_score
   import gmps_pkg::*;
(
   input  logic [GOLD_W-1:0]  gold,
   input  gmps_ctx_type       ctx,
   input  logic [SCORE_W-1:0] same_score,
   input  logic [SCORE_W-1:0] above_score,
   input  logic [SCORE_W-1:0] below_score,
   output logic [SCORE_W-1:0] cell_score
);

   logic [SCORE_W-1:0] best_up;
   logic [SCORE_W-1:0] best_all;
   logic [SCORE_W-1:0] best;
   logic [SCORE_W:0]   sum_wide;

   always_comb begin
      best_up  = (ctx.has_above && (above_score > same_score)) ? above_score : same_score;
      best_all = (ctx.has_below && (below_score > best_up)) ? below_score : best_up;
      best     = ctx.first_col ? '0 : best_all;
      sum_wide = {{(SCORE_W + 1 - GOLD_W){1'b0}}, gold} + {1'b0, best};
      // saturate
      cell_score = sum_wide[SCORE_W] ? SCORE_MAX : sum_wide[SCORE_W-1:0];
   end

endmodule

// ----- design/gmps_store.sv -----
module gmps_store
   import gmps_pkg::*;
#(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [SCORE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]  rd_addr_a,
   input  logic [ADDR_W-1:0]  rd_addr_b,
   output logic [SCORE_W-1:0] rd_data_a,
   output logic [SCORE_W-1:0] rd_data_b
);

   logic [SCORE_W-1:0] mem [DEPTH];
   logic [SCORE_W-1:0] rd_data_a_ff;
   logic [SCORE_W-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // forward a word written at the same edge
      if (wr_en && (wr_addr == rd_addr_a)) begin
         rd_data_a_ff <= wr_data;
      end else begin
         rd_data_a_ff <= mem[rd_addr_a];
      end
      if (wr_en && (wr_addr == rd_addr_b)) begin
         rd_data_b_ff <= wr_data;
      end else begin
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ----- design/grid_max_path_sum.sv -----
// channel   dir  ports                                     word
// req       in   req_valid, req_stall, req_gold            one grid cell, column-major
// rsp       out  rsp_valid, rsp_stall, rsp_best_total      best path sum of one grid
// csr       in   csr_write_en, csr_index, csr_wdata        row_count / col_count
//
// One cell is taken per cycle while req_stall is low; the registered score store is read ahead
// at the row of the next cell and the one below it, so a cell costs one add and two compares.
// The result word appears the cycle after the last cell of a grid is taken.
// req_stall rises only when the last cell is due and a result word is still held.
// Reset is synchronous; it restores 8 rows by 8 columns. A csr write restarts the grid.
module grid_max_path_sum
   import gmps_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [GOLD_W-1:0]      req_gold,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SCORE_W-1:0]     rsp_best_total,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RCNT_W = $clog2(MAX_ROWS + 1);
   localparam int CCNT_W = $clog2(MAX_COLS + 1);
   localparam int ROWS_RESET = (MAX_ROWS < ROW_COUNT_RESET) ? MAX_ROWS : ROW_COUNT_RESET;
   localparam int COLS_RESET = (MAX_COLS < COL_COUNT_RESET) ? MAX_COLS : COL_COUNT_RESET;

   logic [RCNT_W-1:0]  rows_ff, rows_in;
   logic [CCNT_W-1:0]  cols_ff, cols_in;
   logic [ROW_W-1:0]   row_pos_ff, row_pos_in;
   logic [COL_W-1:0]   col_pos_ff, col_pos_in;
   logic [SCORE_W-1:0] above_ff, above_in;
   logic [SCORE_W-1:0] run_best_ff, run_best_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SCORE_W-1:0] rsp_best_ff, rsp_best_in;

   logic [ROW_COUNT_W-1:0] row_raw;
   logic [COL_COUNT_W-1:0] col_raw;
   logic               accept;
   logic               last_row;
   logic               last_col;
   logic               grid_end;
   gmps_ctx_type       ctx;
   logic [SCORE_W-1:0] same_score;
   logic [SCORE_W-1:0] below_score;
   logic [SCORE_W-1:0] cell_score;
   logic [SCORE_W-1:0] final_best;
   logic [ROW_W-1:0]   rd_addr_b;

   assign last_row  = (32'(row_pos_ff) + 1) == 32'(rows_ff);
   assign last_col  = (32'(col_pos_ff) + 1) == 32'(cols_ff);
   assign req_stall = last_row && last_col && rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign grid_end  = accept && last_row && last_col;

   assign ctx.first_col = (col_pos_ff == '0);
   assign ctx.has_above = (row_pos_ff != '0);
   assign ctx.has_below = !last_row;

   gmps_score u_score (
      .gold        (req_gold),
      .ctx         (ctx),
      .same_score  (same_score),
      .above_score (above_ff),
      .below_score (below_score),
      .cell_score  (cell_score)
   );

   gmps_store #(
      .DEPTH  (MAX_ROWS),
      .ADDR_W (ROW_W)
   ) u_store (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (row_pos_ff),
      .wr_data   (cell_score),
      .rd_addr_a (row_pos_in),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (same_score),
      .rd_data_b (below_score)
   );

   assign final_best = (last_col && (cell_score > run_best_ff)) ? cell_score : run_best_ff;

   always_comb begin
      row_raw  = csr_wdata[ROW_COUNT_W-1:0];
      col_raw  = csr_wdata[COL_COUNT_W-1:0];
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      row_pos_in  = row_pos_ff;
      col_pos_in  = col_pos_ff;
      above_in    = above_ff;
      run_best_in = run_best_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_ROW_COUNT: begin
               if (row_raw == '0) begin
                  rows_in = RCNT_W'(1);
               end else if (32'(row_raw) > MAX_ROWS) begin
                  rows_in = RCNT_W'(MAX_ROWS);
               end else begin
                  rows_in = RCNT_W'(row_raw);
               end
            end
            CSR_COL_COUNT: begin
               if (col_raw == '0) begin
                  cols_in = CCNT_W'(1);
               end else if (32'(col_raw) > MAX_COLS) begin
                  cols_in = CCNT_W'(MAX_COLS);
               end else begin
                  cols_in = CCNT_W'(col_raw);
               end
            end
            default: begin
               rows_in = rows_ff;
            end
         endcase
         row_pos_in  = '0;
         col_pos_in  = '0;
         above_in    = '0;
         run_best_in = '0;
      end else if (accept) begin
         above_in    = same_score;
         run_best_in = final_best;
         if (last_row) begin
            row_pos_in = '0;
            if (last_col) begin
               col_pos_in  = '0;
               above_in    = '0;
               run_best_in = '0;
            end else begin
               col_pos_in = col_pos_ff + 1'b1;
            end
         end else begin
            row_pos_in = row_pos_ff + 1'b1;
         end
      end
      // read the row below the next cell; wrap past the store's end, the word is unused there
      if ((32'(row_pos_in) + 1) >= MAX_ROWS) begin
         rd_addr_b = '0;
      end else begin
         rd_addr_b = ROW_W'(32'(row_pos_in) + 1);
      end
   end

   assign rsp_valid_in = grid_end || (rsp_valid_ff && rsp_stall);
   assign rsp_best_in  = grid_end ? final_best : rsp_best_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= RCNT_W'(ROWS_RESET);
         cols_ff      <= CCNT_W'(COLS_RESET);
         row_pos_ff   <= '0;
         col_pos_ff   <= '0;
         above_ff     <= '0;
         run_best_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         row_pos_ff   <= row_pos_in;
         col_pos_ff   <= col_pos_in;
         above_ff     <= above_in;
         run_best_ff  <= run_best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_best_ff <= rsp_best_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_total = rsp_best_ff;

endmodule

// ----- design/gmps_checker.sv -----
module gmps_checker
   import gmps_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [SCORE_W-1:0] rsp_best_total
);

   // a held result word stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_best_total))
      else $error("stalled result word changed");

   // a result only follows a taken cell
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall))
      else $error("result word without a taken cell");

   // back-pressure only from a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with no held result");

endmodule

bind grid_max_path_sum gmps_checker u_gmps_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_best_total (rsp_best_total)
);
